/* sv/okt_pkg.sv */
// okt_pkg: shared types and codes for the ordered keyed timer table
// used by okt_cell, ordered_keyed_timer_table and okt_checker
`default_nettype none

package okt_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_FIND   = 3'd1,
    OP_DELETE = 3'd2,
    OP_TICK   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_EMPTY_SLOT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_LOAD_AT,
    CELL_SHIFT_FROM
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] timer;
  } entry_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] entry_id;
    logic [7:0]  entry_kind;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [15:0] start_time;
    logic [3:0]  slot_index;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  hit_slot;
    logic [15:0] hit_id;
    logic [7:0]  hit_kind;
    logic [7:0]  hit_x;
    logic [7:0]  hit_y;
    logic [15:0] hit_time;
    logic [4:0]  entry_count;
    logic [1:0]  status;
  } out_t;

endpackage

`default_nettype wire

/* sv/okt_cell.sv */
// okt_cell: one slot of the table, holds one entry and passes it to its neighbor
// depends on okt_pkg
`default_nettype none

module okt_cell
  import okt_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int PW    = 4
) (
  input  wire logic     clk,
  input  wire cell_op_t ctl,
  input  wire logic [PW-1:0] pos,
  input  wire entry_t   load,
  input  wire entry_t   neighbor,
  output entry_t        q
);

  entry_t q_next;

  always_comb begin
    q_next = q;
    case (ctl)
      CELL_ROTATE: q_next = neighbor;
      CELL_LOAD_AT: begin
        if (PW'(INDEX) == pos) q_next = load;
      end
      // later entries move one slot toward cell 0 to close the gap
      CELL_SHIFT_FROM: begin
        if (PW'(INDEX) >= pos) q_next = neighbor;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

/* sv/ordered_keyed_timer_table.sv */
// ordered_keyed_timer_table: ordered table of countdown timers as a row of cells
// depends on okt_pkg and okt_cell
//
//   channel  | direction | payload | handshake
//   in       | input     | in_t    | in_valid / in_ready
//   out      | output    | out_t   | out_valid / out_ready
//
// append, delete, clear and unknown codes: result registered at acceptance
// find and tick: the row of cells rotates once past cell 0,
//   which holds the one compare and decrement unit
// one transaction in flight; in_ready is low while a scan runs or a result waits
// reset (rst, synchronous) empties the table; slot contents are not cleared
`default_nettype none

module ordered_keyed_timer_table
  import okt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 4) ? CW : 4;
  localparam int KW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [KW-1:0] k, k_next;
  in_t    req, req_next;
  logic   found, found_next;
  entry_t hit_entry, hit_entry_next;
  logic [3:0] hit_slot, hit_slot_next;
  logic   out_valid_next;
  out_t   out_data_next;

  cell_op_t      cell_ctl;
  logic [PW-1:0] cell_pos;
  entry_t        cell_load;
  entry_t        cell_q [DEPTH];
  entry_t        wrap;

  logic accept;
  logic full;
  logic slot_empty;
  logic last;
  logic active;
  logic match;
  entry_t e_mod;

  assign accept     = in_valid && in_ready;
  assign full       = (count == CW'(DEPTH));
  assign slot_empty = (PW'(in_data.slot_index) >= PW'(count));
  assign last       = (k == KW'(DEPTH - 1));
  assign active     = (CW'(k) < count);

  assign cell_load.id    = in_data.entry_id;
  assign cell_load.kind  = in_data.entry_kind;
  assign cell_load.x     = in_data.pos_x;
  assign cell_load.y     = in_data.pos_y;
  assign cell_load.timer = in_data.start_time;

  // entry in cell 0 is entry k of the table; a tick decrements a nonzero timer on its way round
  always_comb begin
    e_mod = cell_q[0];
    if (req.operation == OP_TICK && active && cell_q[0].timer != 16'd0) begin
      e_mod.timer = cell_q[0].timer - 16'd1;
    end
    match = 1'b0;
    if (active) begin
      if (req.operation == OP_TICK) begin
        match = (e_mod.timer == 16'd0);
      end else begin
        match = (e_mod.x == req.pos_x) && (e_mod.y == req.pos_y);
      end
    end
  end

  assign wrap = e_mod;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    okt_cell #(
      .INDEX (i),
      .PW    (PW)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .pos      (cell_pos),
      .load     (cell_load),
      .neighbor ((i == DEPTH - 1) ? wrap : cell_q[(i + 1) % DEPTH]),
      .q        (cell_q[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (in_data.operation == OP_FIND || in_data.operation == OP_TICK)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready = 1'b0;
    cell_ctl = CELL_HOLD;
    cell_pos = PW'(count);
    case (state)
      S_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (accept && in_data.operation == OP_APPEND && !full) begin
          cell_ctl = CELL_LOAD_AT;
          cell_pos = PW'(count);
        end else if (accept && in_data.operation == OP_DELETE && !slot_empty) begin
          cell_ctl = CELL_SHIFT_FROM;
          cell_pos = PW'(in_data.slot_index);
        end
      end
      S_SCAN: cell_ctl = CELL_ROTATE;
      default: cell_ctl = CELL_HOLD;
    endcase
  end

  // datapath next values
  always_comb begin
    count_next     = count;
    k_next         = k;
    req_next       = req;
    found_next     = found;
    hit_entry_next = hit_entry;
    hit_slot_next  = hit_slot;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;

    if (state == S_IDLE && accept) begin
      req_next   = in_data;
      k_next     = '0;
      found_next = 1'b0;
      out_data_next = '0;
      case (in_data.operation)
        OP_APPEND: begin
          if (full) out_data_next.status = STAT_FULL;
          else count_next = count + CW'(1);
        end
        OP_DELETE: begin
          if (slot_empty) out_data_next.status = STAT_EMPTY_SLOT;
          else count_next = count - CW'(1);
        end
        OP_CLEAR: count_next = '0;
        default: count_next = count;
      endcase
      out_data_next.entry_count = 5'(count_next);
      if (in_data.operation != OP_FIND && in_data.operation != OP_TICK) begin
        out_valid_next = 1'b1;
      end
    end

    if (state == S_SCAN) begin
      k_next = k + KW'(1);
      if (match && !found) begin
        found_next     = 1'b1;
        hit_entry_next = e_mod;
        hit_slot_next  = 4'(k);
      end
      if (last) begin
        out_valid_next = 1'b1;
        out_data_next  = '0;
        out_data_next.entry_count = 5'(count);
        if (found_next) begin
          out_data_next.hit      = 1'b1;
          out_data_next.hit_slot = hit_slot_next;
          out_data_next.hit_id   = hit_entry_next.id;
          out_data_next.hit_kind = hit_entry_next.kind;
          out_data_next.hit_x    = hit_entry_next.x;
          out_data_next.hit_y    = hit_entry_next.y;
          out_data_next.hit_time = hit_entry_next.timer;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
      k         <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      found     <= found_next;
      k         <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    req       <= req_next;
    hit_entry <= hit_entry_next;
    hit_slot  <= hit_slot_next;
    out_data  <= out_data_next;
  end

endmodule

`default_nettype wire

/* sv/okt_checker.sv */
// okt_checker: port-level assertions for ordered_keyed_timer_table, bound to it
// depends on okt_pkg
`default_nettype none

module okt_checker
  import okt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire in_t  in_data,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no new transaction while a result is stalled
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // no report means zero report fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.hit_slot == 4'd0 && out_data.hit_id == 16'd0
      && out_data.hit_kind == 8'd0 && out_data.hit_x == 8'd0 && out_data.hit_y == 8'd0
      && out_data.hit_time == 16'd0)
    else $error("report fields set without hit");

  // errors come only from append and delete, which never report
  a_status_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STAT_OK |-> !out_data.hit)
    else $error("hit together with error status");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH >= 32) || (int'(out_data.entry_count) <= DEPTH))
    else $error("entry count above depth");

endmodule

bind ordered_keyed_timer_table okt_checker #(.DEPTH(DEPTH)) u_okt_checker (.*);

`default_nettype wire
